// ===== rtl/glt_pkg.sv =====
// Shared types, codes and helper functions for the glyph text layout unit.
// No dependencies; every other file in rtl/ refers to this package by scope.
`timescale 1ns / 1ps

package glt_pkg;

    // Glyph table size default
    localparam int GLYPH_SLOTS_DEFAULT = 256;

    // Input opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_CHAR  = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_LOW_CODE    = 2'd0;
    localparam logic [1:0] CFG_HIGH_CODE   = 2'd1;
    localparam logic [1:0] CFG_LINE_HEIGHT = 2'd2;

    localparam logic [7:0] LOW_CODE_RESET    = 8'd32;
    localparam logic [7:0] HIGH_CODE_RESET   = 8'd127;
    localparam logic [7:0] LINE_HEIGHT_RESET = 8'd16;

    // Actions held in the pen stage
    localparam logic [1:0] ACT_BEGIN   = 2'd0;
    localparam logic [1:0] ACT_DRAW    = 2'd1;
    localparam logic [1:0] ACT_NEWLINE = 2'd2;
    localparam logic [1:0] ACT_END     = 2'd3;

    // Result kinds
    localparam logic KIND_QUAD  = 1'b0;
    localparam logic KIND_WIDTH = 1'b1;

    // One glyph table entry, 112 bits
    typedef struct packed {
        logic signed [15:0] offset;
        logic [15:0]        width;
        logic signed [15:0] advance;
        logic [15:0]        tex_left;
        logic [15:0]        tex_top;
        logic [15:0]        tex_right;
        logic [15:0]        tex_bottom;
    } glyph_t;

    // Item held in the pen stage
    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic               zero_glyph;
    } pen_item_t;

    // Pen stage to quad stage
    typedef struct packed {
        logic               kind;
        logic signed [15:0] pen_x;
        logic signed [15:0] pen_y;
        logic [15:0]        glyph_width;
        logic [7:0]         line_height;
        logic [15:0]        tex_left;
        logic [15:0]        tex_top;
        logic [15:0]        tex_right;
        logic [15:0]        tex_bottom;
        logic [15:0]        string_width;
    } pre_result_t;

    // Saturate a pen sum to 16 bits signed
    function automatic logic signed [15:0] sat_pen(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767)
            r = 16'sh7fff;
        else if (v < -17'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // Saturate a half-pixel edge to 17 bits signed
    function automatic logic signed [16:0] sat_edge(input logic signed [19:0] v);
        logic signed [16:0] r;
        if (v > 20'sd65535)
            r = 17'sh0ffff;
        else if (v < -20'sd65536)
            r = 17'sh10000;
        else
            r = v[16:0];
        return r;
    endfunction

endpackage

// ===== rtl/glyph_text_layout_unit.sv =====
// Glyph text layout unit: glyph table lookup, pen update, quad generation.
// Pipeline: the input transfer loads the table read and pen item; the pen step then
// registers into the quad stage, and the quad edges into the output register.
// Throughput: one item per cycle unless results stall; pen registers feed back directly.
// Reset: pen, line origin, widest line and pipeline valids clear; config
// registers take 32/127/16; the glyph table is not cleared and holds junk.
`timescale 1ns / 1ps

module glyph_text_layout_unit #(
    parameter int GLYPH_SLOTS = glt_pkg::GLYPH_SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    // Configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    // Input items
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [7:0]         code,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic signed [15:0] glyph_offset,
    input  logic [15:0]        glyph_width,
    input  logic signed [15:0] glyph_advance,
    input  logic [15:0]        tex_left,
    input  logic [15:0]        tex_top,
    input  logic [15:0]        tex_right,
    input  logic [15:0]        tex_bottom,
    // Results
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic signed [16:0] quad_left,
    output logic signed [16:0] quad_top,
    output logic signed [16:0] quad_right,
    output logic signed [16:0] quad_bottom,
    output logic [15:0]        out_tex_left,
    output logic [15:0]        out_tex_top,
    output logic [15:0]        out_tex_right,
    output logic [15:0]        out_tex_bottom,
    output logic [15:0]        string_width
);

    localparam int AW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;

    logic [7:0] low_code_reg;
    logic [7:0] high_code_reg;
    logic [7:0] line_height_reg;

    logic                 accept;
    logic                 is_newline;
    logic                 in_range;
    logic                 is_draw;
    logic                 takes_stage;
    logic [7:0]           slot;
    logic                 slot_in_table;
    logic                 load_in_table;
    logic [1:0]           action;

    logic                 s1_valid_reg;
    glt_pkg::pen_item_t   s1_reg;
    glt_pkg::pen_item_t   s1_next;
    logic                 s1_emits;
    logic                 s1_fire;

    glt_pkg::glyph_t      wr_glyph;
    glt_pkg::glyph_t      rd_glyph;
    glt_pkg::pre_result_t pre;
    logic                 s2_free;
    logic                 s2_busy;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_code_reg    <= glt_pkg::LOW_CODE_RESET;
            high_code_reg   <= glt_pkg::HIGH_CODE_RESET;
            line_height_reg <= glt_pkg::LINE_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                glt_pkg::CFG_LOW_CODE:    low_code_reg    <= cfg_data;
                glt_pkg::CFG_HIGH_CODE:   high_code_reg   <= cfg_data;
                glt_pkg::CFG_LINE_HEIGHT: line_height_reg <= cfg_data;
                default:                  low_code_reg    <= low_code_reg;
            endcase
        end
    end

    // Input decode
    assign accept        = in_valid && in_ready;
    assign is_newline    = (opcode == glt_pkg::OP_CHAR) && (code == glt_pkg::NEWLINE_CODE);
    assign in_range      = (code >= low_code_reg) && (code <= high_code_reg);
    assign is_draw       = (opcode == glt_pkg::OP_CHAR) && !is_newline && in_range;
    assign slot          = code - low_code_reg;
    assign slot_in_table = (32'(slot) < GLYPH_SLOTS);
    assign load_in_table = (32'(code) < GLYPH_SLOTS);
    assign takes_stage   = (opcode == glt_pkg::OP_BEGIN) || (opcode == glt_pkg::OP_END)
                           || is_newline || is_draw;

    always_comb
    begin
        case (opcode)
            glt_pkg::OP_BEGIN: action = glt_pkg::ACT_BEGIN;
            glt_pkg::OP_END:   action = glt_pkg::ACT_END;
            default:           action = is_newline ? glt_pkg::ACT_NEWLINE : glt_pkg::ACT_DRAW;
        endcase
    end

    assign s1_next.action     = action;
    assign s1_next.start_x    = start_x;
    assign s1_next.start_y    = start_y;
    assign s1_next.zero_glyph = !slot_in_table;

    // Pen stage handshake
    assign s1_emits = (s1_reg.action == glt_pkg::ACT_DRAW) || (s1_reg.action == glt_pkg::ACT_END);
    assign s1_fire  = s1_valid_reg && (!s1_emits || s2_free);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= accept && takes_stage;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && takes_stage)
        begin
            s1_reg <= s1_next;
        end
    end

    // Glyph table
    assign wr_glyph.offset     = glyph_offset;
    assign wr_glyph.width      = glyph_width;
    assign wr_glyph.advance    = glyph_advance;
    assign wr_glyph.tex_left   = tex_left;
    assign wr_glyph.tex_top    = tex_top;
    assign wr_glyph.tex_right  = tex_right;
    assign wr_glyph.tex_bottom = tex_bottom;

    glt_glyph_ram #(
        .SLOTS (GLYPH_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (accept && (opcode == glt_pkg::OP_LOAD) && load_in_table),
        .wr_addr (code[AW-1:0]),
        .wr_data (wr_glyph),
        .rd_en   (accept && is_draw),
        .rd_addr (slot[AW-1:0]),
        .rd_data (rd_glyph)
    );

    // Pen update
    glt_pen u_pen (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s1_fire),
        .item        (s1_reg),
        .glyph       (rd_glyph),
        .line_height (line_height_reg),
        .pre         (pre)
    );

    // Quad edges and result register
    glt_quad u_quad (
        .clk            (clk),
        .rst_n          (rst_n),
        .pre_valid      (s1_fire && s1_emits),
        .pre            (pre),
        .s2_free        (s2_free),
        .s2_busy        (s2_busy),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .quad_left      (quad_left),
        .quad_top       (quad_top),
        .quad_right     (quad_right),
        .quad_bottom    (quad_bottom),
        .out_tex_left   (out_tex_left),
        .out_tex_top    (out_tex_top),
        .out_tex_right  (out_tex_right),
        .out_tex_bottom (out_tex_bottom),
        .string_width   (string_width)
    );

`ifndef SYNTHESIS
    // A result-producing item cannot leave the pen stage while both later stages are full
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emits && s2_busy && out_valid && !out_ready) |-> !in_ready)
        else $error("pen stage accepted input while blocked");

    // A width result carries no quad edges
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == glt_pkg::KIND_WIDTH) |->
        (quad_left == 17'sd0 && quad_top == 17'sd0 && quad_right == 17'sd0
         && quad_bottom == 17'sd0))
        else $error("width result with nonzero quad");

    // A quad result carries no string width
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == glt_pkg::KIND_QUAD) |-> (string_width == 16'd0))
        else $error("quad result with nonzero string width");

    // Quad right edge never lies left of its left edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == glt_pkg::KIND_QUAD) |-> (quad_right >= quad_left))
        else $error("quad right edge before left edge");
`endif

endmodule

// ===== rtl/glt_glyph_ram.sv =====
// Glyph table: single write port, single registered read port.
// Uses glt_pkg::glyph_t for the entry layout.
`timescale 1ns / 1ps

module glt_glyph_ram #(
    parameter int SLOTS = glt_pkg::GLYPH_SLOTS_DEFAULT,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  glt_pkg::glyph_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output glt_pkg::glyph_t rd_data
);

    glt_pkg::glyph_t mem [SLOTS];
    glt_pkg::glyph_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/glt_pen.sv =====
// Pen state engine: pen position, line origin and widest line.
// Consumes the glyph read from glt_glyph_ram; uses glt_pkg types and functions.
`timescale 1ns / 1ps

module glt_pen (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  glt_pkg::pen_item_t   item,
    input  glt_pkg::glyph_t      glyph,
    input  logic [7:0]           line_height,
    output glt_pkg::pre_result_t pre
);

    logic signed [15:0] pen_x_reg, pen_x_next;
    logic signed [15:0] pen_y_reg, pen_y_next;
    logic signed [15:0] origin_reg, origin_next;
    logic [15:0]        widest_reg, widest_next;

    glt_pkg::glyph_t    g;
    logic signed [15:0] pen_mid;
    logic signed [15:0] pen_after;
    logic signed [16:0] diff;
    logic [15:0]        line_w;
    logic [15:0]        widest_max;
    logic signed [16:0] y_sum;

    // Glyph beyond the table reads as all zero
    assign g = item.zero_glyph ? '0 : glyph;

    // Pen steps: offset before drawing, advance after
    assign pen_mid   = glt_pkg::sat_pen(17'(pen_x_reg) + 17'(g.offset));
    assign pen_after = glt_pkg::sat_pen(17'(pen_mid) + 17'(g.advance));

    // Current line width, clamped at zero
    assign diff       = 17'(pen_x_reg) - 17'(origin_reg);
    assign line_w     = diff[16] ? 16'd0 : diff[15:0];
    assign widest_max = (line_w > widest_reg) ? line_w : widest_reg;
    assign y_sum      = 17'(pen_y_reg) + $signed({9'd0, line_height});

    // Next state
    always_comb
    begin
        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        origin_next = origin_reg;
        widest_next = widest_reg;
        case (item.action)
            glt_pkg::ACT_BEGIN:
            begin
                pen_x_next  = item.start_x;
                pen_y_next  = item.start_y;
                origin_next = item.start_x;
                widest_next = 16'd0;
            end
            glt_pkg::ACT_DRAW:
            begin
                pen_x_next = pen_after;
            end
            glt_pkg::ACT_NEWLINE:
            begin
                widest_next = widest_max;
                pen_x_next  = origin_reg;
                pen_y_next  = glt_pkg::sat_pen(y_sum);
            end
            default:
            begin
                pen_x_next = pen_x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            origin_reg <= '0;
            widest_reg <= '0;
        end
        else if (fire)
        begin
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            origin_reg <= origin_next;
            widest_reg <= widest_next;
        end
    end

    // Result handed to the quad stage
    always_comb
    begin
        pre = '0;
        if (item.action == glt_pkg::ACT_END)
        begin
            pre.kind         = glt_pkg::KIND_WIDTH;
            pre.string_width = widest_max;
        end
        else
        begin
            pre.kind        = glt_pkg::KIND_QUAD;
            pre.pen_x       = pen_mid;
            pre.pen_y       = pen_y_reg;
            pre.glyph_width = g.width;
            pre.line_height = line_height;
            pre.tex_left    = g.tex_left;
            pre.tex_top     = g.tex_top;
            pre.tex_right   = g.tex_right;
            pre.tex_bottom  = g.tex_bottom;
        end
    end

endmodule

// ===== rtl/glt_quad.sv =====
// Quad stage and output register: half-pixel edges with saturation.
// Takes glt_pkg::pre_result_t from glt_pen; drives the result channel.
`timescale 1ns / 1ps

module glt_quad (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pre_valid,
    input  glt_pkg::pre_result_t pre,
    output logic                 s2_free,
    output logic                 s2_busy,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 kind,
    output logic signed [16:0]   quad_left,
    output logic signed [16:0]   quad_top,
    output logic signed [16:0]   quad_right,
    output logic signed [16:0]   quad_bottom,
    output logic [15:0]          out_tex_left,
    output logic [15:0]          out_tex_top,
    output logic [15:0]          out_tex_right,
    output logic [15:0]          out_tex_bottom,
    output logic [15:0]          string_width
);

    logic                 s2_valid_reg;
    glt_pkg::pre_result_t s2_reg;
    logic                 out_valid_reg;
    logic                 out_load;
    logic                 s2_adv;

    logic signed [19:0]   left_raw, top_raw, right_raw, bottom_raw;
    logic                 is_quad;

    logic                 kind_reg;
    logic signed [16:0]   left_reg, top_reg, right_reg, bottom_reg;
    logic [15:0]          tl_reg, tt_reg, tr_reg, tb_reg, sw_reg;

    // Stage handshake
    assign out_load = !out_valid_reg || out_ready;
    assign s2_adv   = s2_valid_reg && out_load;
    assign s2_free  = !s2_valid_reg || out_load;
    assign s2_busy  = s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_free)
            begin
                s2_valid_reg <= pre_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && pre_valid)
        begin
            s2_reg <= pre;
        end
    end

    // Edges: corner minus one half, extent plus one, in half pixels
    assign is_quad    = (s2_reg.kind == glt_pkg::KIND_QUAD);
    assign left_raw   = $signed({{3{s2_reg.pen_x[15]}}, s2_reg.pen_x, 1'b0}) - 20'sd1;
    assign top_raw    = $signed({{3{s2_reg.pen_y[15]}}, s2_reg.pen_y, 1'b0}) - 20'sd1;
    assign right_raw  = left_raw + $signed({3'd0, s2_reg.glyph_width, 1'b0}) + 20'sd2;
    assign bottom_raw = top_raw + $signed({11'd0, s2_reg.line_height, 1'b0}) + 20'sd2;

    // Output register
    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            kind_reg   <= s2_reg.kind;
            left_reg   <= is_quad ? glt_pkg::sat_edge(left_raw) : 17'sd0;
            top_reg    <= is_quad ? glt_pkg::sat_edge(top_raw) : 17'sd0;
            right_reg  <= is_quad ? glt_pkg::sat_edge(right_raw) : 17'sd0;
            bottom_reg <= is_quad ? glt_pkg::sat_edge(bottom_raw) : 17'sd0;
            tl_reg     <= s2_reg.tex_left;
            tt_reg     <= s2_reg.tex_top;
            tr_reg     <= s2_reg.tex_right;
            tb_reg     <= s2_reg.tex_bottom;
            sw_reg     <= s2_reg.string_width;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign quad_left      = left_reg;
    assign quad_top       = top_reg;
    assign quad_right     = right_reg;
    assign quad_bottom    = bottom_reg;
    assign out_tex_left   = tl_reg;
    assign out_tex_top    = tt_reg;
    assign out_tex_right  = tr_reg;
    assign out_tex_bottom = tb_reg;
    assign string_width   = sw_reg;

endmodule
